// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: sv/dwos_pkg.sv
// ----------------------------------------------------------------------------
// dwos_pkg
// Types and constants for the daily window output scheduler.
// ----------------------------------------------------------------------------
package dwos_pkg;

   // Number of daily window slots
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Second-of-day width and time conversion factors
   localparam int DAY_W = 17;
   localparam logic [DAY_W-1:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [DAY_W-1:0] SEC_PER_MIN  = 17'd60;

   // Item kinds carried on the request tuser
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// File: sv/daily_window_output_scheduler_top.sv
// ----------------------------------------------------------------------------
// daily_window_output_scheduler_top
// Daily on/off window table driving one output level.
// ----------------------------------------------------------------------------
// Input channel req_*: tuser selects a time tick or a slot write. A slot write
// stores one window (start, end as second of day) and gives no result. A tick
// walks all slots, later slots overriding earlier ones, applies the button
// and gives exactly one result on the rsp_* channel.
// Sequencing: a tick walks the slots one at a time through the single window
// compare unit, which is fed by the slot memory's registered read port, then
// passes a drain step and a finish step that loads the result register. A
// tick is not through until that finish step, and no new request is taken
// before the sequencer is back in idle.
// req_tready is high only while the sequencer is idle.
// Reset: all slots read as empty, the output is off and no result is pending.
// Stall: the result sits in an output register; a new tick may be accepted and
// walked meanwhile, and it waits in its finish step until that register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module daily_window_output_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] hours, [10:5] minutes, [16:11] seconds, [48:17] stamp, [49] button,
   // [53:50] slot, [70:54] on_seconds, [87:71] off_seconds
   input  logic [87:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] level, [1] changed, [33:2] elapsed, [39:34] zero
   output logic [39:0] rsp_tdata,
   // [0] elapsed_valid
   output logic        rsp_tuser
);

   localparam int DW = dwos_pkg::DAY_W;
   localparam int SW = dwos_pkg::SLOT_W;
   localparam logic [SW-1:0] LAST_IDX = SW'(dwos_pkg::SLOTS - 1);

   // Request fields
   logic [4:0]    req_hours;
   logic [5:0]    req_minutes;
   logic [5:0]    req_seconds;
   logic [31:0]   req_stamp;
   logic          req_button;
   logic [3:0]    req_slot;
   logic [DW-1:0] req_on_seconds;
   logic [DW-1:0] req_off_seconds;

   assign req_hours       = req_tdata[4:0];
   assign req_minutes     = req_tdata[10:5];
   assign req_seconds     = req_tdata[16:11];
   assign req_stamp       = req_tdata[48:17];
   assign req_button      = req_tdata[49];
   assign req_slot        = req_tdata[53:50];
   assign req_on_seconds  = req_tdata[70:54];
   assign req_off_seconds = req_tdata[87:71];

   // Sequencer and datapath registers
   dwos_pkg::state_type state_ff, state_in;
   logic [SW-1:0]              idx_ff, idx_in;
   logic                       pipe_vld_ff, pipe_vld_in;
   logic                       want_ff, want_in;
   logic [DW-1:0]              now_ff, now_in;
   logic [31:0]                stamp_ff, stamp_in;
   logic                       button_ff, button_in;
   logic                       level_ff, level_in;
   logic [31:0]                on_stamp_ff, on_stamp_in;
   logic [dwos_pkg::SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_level_ff, rsp_level_in;
   logic                       rsp_changed_ff, rsp_changed_in;
   logic                       rsp_ev_ff, rsp_ev_in;
   logic [31:0]                rsp_elapsed_ff, rsp_elapsed_in;

   // Slot memory and its registered read port
   logic [DW-1:0] start_mem [dwos_pkg::SLOTS];
   logic [DW-1:0] end_mem   [dwos_pkg::SLOTS];
   logic [DW-1:0] rd_start_ff;
   logic [DW-1:0] rd_end_ff;
   logic          rd_hit_ff;

   // Control decodes
   logic          req_fire;
   logic          tick_fire;
   logic          wr_fire;
   logic          wr_en;
   logic [SW-1:0] wr_idx;
   logic          issue_rd;
   logic          out_free;
   logic          finish_fire;

   // Compare unit and finish signals
   logic [DW-1:0] win_a;
   logic [DW-1:0] win_b;
   logic          want_final;
   logic          level_change;

   assign req_fire  = req_tvalid && req_tready;
   assign tick_fire = req_fire && (req_tuser == dwos_pkg::KIND_TICK);
   assign wr_fire   = req_fire && (req_tuser == dwos_pkg::KIND_WRITE);
   assign wr_en     = wr_fire && (32'(req_slot) < 32'(dwos_pkg::SLOTS));
   assign wr_idx    = SW'(req_slot);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwos_pkg::ST_IDLE: begin
            if (tick_fire) state_in = dwos_pkg::ST_WALK;
         end
         dwos_pkg::ST_WALK: begin
            if (idx_ff == LAST_IDX) state_in = dwos_pkg::ST_DRAIN;
         end
         dwos_pkg::ST_DRAIN: begin
            state_in = dwos_pkg::ST_FINISH;
         end
         dwos_pkg::ST_FINISH: begin
            if (out_free) state_in = dwos_pkg::ST_IDLE;
         end
         default: begin
            state_in = dwos_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      issue_rd    = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         dwos_pkg::ST_IDLE:   req_tready  = 1'b1;
         dwos_pkg::ST_WALK:   issue_rd    = 1'b1;
         dwos_pkg::ST_DRAIN:  finish_fire = 1'b0;
         dwos_pkg::ST_FINISH: finish_fire = out_free;
         default:             req_tready  = 1'b0;
      endcase
   end

   // Empty (never written) slots read as start == end == 0
   assign win_a = rd_hit_ff ? rd_start_ff : '0;
   assign win_b = rd_hit_ff ? rd_end_ff   : '0;

   // Walk counter, captured tick fields and the window compare unit
   always_comb begin
      idx_in      = idx_ff;
      pipe_vld_in = issue_rd;
      want_in     = want_ff;
      now_in      = now_ff;
      stamp_in    = stamp_ff;
      button_in   = button_ff;
      if (tick_fire) begin
         idx_in    = '0;
         want_in   = 1'b0;
         now_in    = DW'(req_hours) * dwos_pkg::SEC_PER_HOUR
                   + DW'(req_minutes) * dwos_pkg::SEC_PER_MIN
                   + DW'(req_seconds);
         stamp_in  = req_stamp;
         button_in = req_button;
      end else begin
         if (issue_rd && (idx_ff != LAST_IDX)) idx_in = idx_ff + SW'(1);
         // Apply one window per cycle; later slots override earlier ones
         if (pipe_vld_ff && (win_a != win_b)) begin
            if (win_a < win_b) begin
               if (now_ff >= win_b) begin
                  want_in = 1'b0;
               end else if (now_ff >= win_a) begin
                  want_in = 1'b1;
               end
            end else begin
               want_in = (now_ff >= win_a) || (now_ff < win_b);
            end
         end
      end
   end

   // Final level, change report and elapsed on-time
   assign want_final   = want_ff || button_ff;
   assign level_change = want_final != level_ff;

   always_comb begin
      level_in       = level_ff;
      on_stamp_in    = on_stamp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      if (finish_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_level_in   = want_final;
         rsp_changed_in = level_change;
         rsp_ev_in      = 1'b0;
         rsp_elapsed_in = '0;
         if (level_change) begin
            level_in = want_final;
            if (want_final) begin
               on_stamp_in = stamp_ff;
            end else begin
               rsp_ev_in      = 1'b1;
               rsp_elapsed_in = stamp_ff - on_stamp_ff;
            end
         end
      end
   end

   // Mark written slots
   always_comb begin
      slot_vld_in = slot_vld_ff;
      if (wr_en) slot_vld_in[wr_idx] = 1'b1;
   end

   // Write and read the slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx] <= req_on_seconds;
         end_mem[wr_idx]   <= req_off_seconds;
      end
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[idx_ff];
      rd_end_ff   <= end_mem[idx_ff];
      rd_hit_ff   <= slot_vld_ff[idx_ff];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwos_pkg::ST_IDLE;
         pipe_vld_ff  <= 1'b0;
         level_ff     <= 1'b0;
         on_stamp_ff  <= '0;
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         level_ff     <= level_in;
         on_stamp_ff  <= on_stamp_in;
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      want_ff        <= want_in;
      now_ff         <= now_in;
      stamp_ff       <= stamp_in;
      button_ff      <= button_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
   end

   // Drive the result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_elapsed_ff, rsp_changed_ff, rsp_level_ff};
   assign rsp_tuser  = rsp_ev_ff;

   // Checks
   `ASSERT_IMPLY(a_elapsed_on_fall, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[0] && rsp_tdata[1], "elapsed reported without a turn-off")
   `ASSERT_IMPLY(a_level_reported, clock, reset, !$past(reset) && !$stable(level_ff), rsp_valid_ff && rsp_changed_ff && (rsp_level_ff == level_ff), "level changed without a change result")
   `ASSERT_IMPLY(a_idle_no_walk, clock, reset, req_tready, !pipe_vld_ff, "request taken while slot walk in flight")

endmodule
